### rtl/core/fbpa_pkg.sv
// Package for the fixed block pool allocator: widths, status and command codes,
// register indexes, channel word types and controller/datapath interface structs.
// Depends on nothing.
`default_nettype none

package fbpa_pkg;

    // Field widths of the channel words and configuration registers.
    localparam int unsigned CMD_W     = 1;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OFFSET_W  = 22;
    localparam int unsigned BYTES_W   = 13;
    localparam int unsigned CAP_W     = 11;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_IDX_W = 1;

    // Head, high-water mark and link entries all count blocks up to the pool limit.
    localparam int unsigned HEAD_W    = 11;

    // Hard limit on the number of blocks, whatever the pool is built for.
    localparam int unsigned POOL_LIMIT      = 1024;
    localparam int unsigned DEF_MAX_BLOCKS  = 1024;

    // Block size bounds: at least the link, at most 4 KiB.
    localparam logic [BYTES_W-1:0] BYTES_MIN   = 13'd4;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd4;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADIX = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_CAPACITY = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] free_index;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    block_index;
        logic [OFFSET_W-1:0] byte_offset;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input word and load the result register
        logic link_load;  // the head's link has arrived from the link store
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic list_pop;   // the offered word allocates a previously freed block
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: controller, datapath and checks.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dpath (which holds fbpa_ram).
`default_nettype none

// The allocator hands out fixed-size blocks from a pool kept as a free list
// threaded through a link store. Each input word is one command: allocate
// returns the head block's index and its byte offset (index times the block
// size), free pushes the given block onto the list. Blocks that were never
// handed out are taken lazily from a high-water mark, so no link is written
// for them and the link store needs no clearing pass after reset. Freeing,
// allocating a never-used block, and the two error cases (pool exhausted,
// free index at or above the high-water mark) let the next word be taken at
// once. Allocating a previously freed block holds off the next word, as the
// successor of the head comes from the link store's registered read port and
// the next command cannot start before the new head is known. The single
// result register takes a new word only when it is empty or is being read in
// the same cycle, so a result that waits on m_ready holds off the input.
// Double free is not detected. Configuration must be written only while no
// command is in flight; block sizes are clamped to 4..4096 and the capacity
// to the pool depth.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Command word channel.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_word_t             s_data,

    // Result word channel.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_data,

    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    ctrl_t ctrl;
    stat_t stat;

    // The controller decides when a word is taken and tracks the link wait.
    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // The datapath holds all pool state and builds the result word.
    fbpa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // While the head's link is in flight, no new word may be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.link_load |-> !s_ready)
        else $error("word accepted while the free list head was being reloaded");

    // Taking a previously freed block must be followed by the link reload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.accept && stat.list_pop) |=> ctrl.link_load)
        else $error("free list pop was not followed by a link reload");

    // Every accepted word produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept |=> m_valid)
        else $error("accepted word produced no result");

    // Only a successful allocation carries an index and an offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STATUS_ALLOC)) |->
            ((m_data.block_index == '0) && (m_data.byte_offset == '0)))
        else $error("non-allocation result carries a block index or offset");

endmodule

`default_nettype wire

### rtl/core/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module fbpa_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/fbpa_ctrl.sv
// Controller of the fixed block pool allocator: input acceptance, link wait
// state and the result valid flag. Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LINK = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // A new word is taken when no link read is pending and the result register
    // is empty or being emptied in this cycle.
    assign s_ready        = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign ctrl.accept    = s_valid && s_ready;
    assign ctrl.link_load = (state_reg == S_LINK);
    assign m_valid        = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctrl.accept && stat.list_pop) begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.accept) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fbpa_dpath.sv
// Datapath of the fixed block pool allocator: configuration registers, free
// list head, high-water mark, link store, offset multiplier and result register.
// Depends on fbpa_pkg and fbpa_ram.
`default_nettype none

module fbpa_dpath
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctrl_t                ctrl,
    output stat_t                     stat,
    input  wire in_word_t             s_data,
    output out_word_t                 m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int unsigned POOL_DEPTH = (MAX_BLOCKS < POOL_LIMIT) ? MAX_BLOCKS : POOL_LIMIT;
    localparam int unsigned ADDR_W     = $clog2(POOL_DEPTH);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(POOL_DEPTH);

    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [HEAD_W-1:0]  hw_reg, hw_next;
    out_word_t          out_reg, out_next;

    logic               at_hw;
    logic               exhausted;
    logic               bad_free;
    logic [IDX_W-1:0]   alloc_idx;
    logic [IDX_W+BYTES_W-1:0] product;
    logic [HEAD_W-1:0]  link_rd;
    logic               link_wr;
    logic               link_rd_en;

    assign at_hw     = (head_reg == hw_reg);
    assign exhausted = at_hw && (hw_reg >= cap_reg);
    assign bad_free  = ({1'b0, s_data.free_index} >= hw_reg);
    assign stat.list_pop = (s_data.cmd == CMD_ALLOC) && !at_hw;

    // A fresh block is the high-water block; otherwise the head itself. Both are
    // below the pool limit whenever an allocation succeeds.
    assign alloc_idx = at_hw ? hw_reg[IDX_W-1:0] : head_reg[IDX_W-1:0];
    assign product   = {{BYTES_W{1'b0}}, alloc_idx} * {{IDX_W{1'b0}}, bytes_reg};

    assign link_wr    = ctrl.accept && (s_data.cmd == CMD_FREE) && !bad_free;
    assign link_rd_en = ctrl.accept && stat.list_pop;

    fbpa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_store (
        .aclk    (aclk),
        .wr_en   (link_wr),
        .wr_addr (s_data.free_index[ADDR_W-1:0]),
        .wr_data (head_reg),
        .rd_en   (link_rd_en),
        .rd_addr (head_reg[ADDR_W-1:0]),
        .rd_data (link_rd)
    );

    // Configuration values are clamped to their legal ranges as they are written.
    always_comb begin
        bytes_next = bytes_reg;
        cap_next   = cap_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLOCK_BYTES: begin
                    if (cfg_wdata < BYTES_MIN) begin
                        bytes_next = BYTES_MIN;
                    end else if (cfg_wdata > BYTES_MAX) begin
                        bytes_next = BYTES_MAX;
                    end else begin
                        bytes_next = cfg_wdata;
                    end
                end
                REG_BLOCK_CAPACITY: begin
                    if (cfg_wdata[CAP_W-1:0] > CAP_MAX) begin
                        cap_next = CAP_MAX;
                    end else begin
                        cap_next = cfg_wdata[CAP_W-1:0];
                    end
                end
                default: begin
                    bytes_next = bytes_reg;
                end
            endcase
        end
    end

    always_comb begin
        head_next = head_reg;
        hw_next   = hw_reg;
        out_next  = out_reg;
        if (ctrl.link_load) begin
            head_next = link_rd;
        end
        if (ctrl.accept) begin
            out_next.block_index = '0;
            out_next.byte_offset = '0;
            if (s_data.cmd == CMD_ALLOC) begin
                if (exhausted) begin
                    out_next.status = STATUS_EMPTY;
                end else begin
                    out_next.status      = STATUS_ALLOC;
                    out_next.block_index = alloc_idx;
                    out_next.byte_offset = product[OFFSET_W-1:0];
                    if (at_hw) begin
                        hw_next   = hw_reg + 1'b1;
                        head_next = hw_reg + 1'b1;
                    end
                end
            end else if (bad_free) begin
                out_next.status = STATUS_BADIX;
            end else begin
                out_next.status = STATUS_FREED;
                head_next       = {1'b0, s_data.free_index};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= BYTES_RESET;
            cap_reg   <= CAP_MAX;
            head_reg  <= '0;
            hw_reg    <= '0;
        end else begin
            bytes_reg <= bytes_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            hw_reg    <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire
